### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond) \
  `ASSERT_CLK(name, !(cond))

`else

`define ASSERT_CLK(name, prop)
`define ASSERT_NEVER(name, cond)

`endif

`endif

### sv/ps2mct_pkg.sv
`timescale 1ns / 1ps

package ps2mct_pkg;

  // Header byte bit positions
  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned HdrXOvfBit  = 6;
  localparam int unsigned HdrYOvfBit  = 7;

  // Movement arithmetic
  localparam logic [9:0]  OvfExtra  = 10'd255;
  localparam logic [8:0]  NegBase   = 9'd256;

  // Configuration registers
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 12;
  localparam logic [CfgIdxW-1:0] CfgMaxX = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxY = 1'b1;
  localparam logic [11:0] MaxXReset = 12'd320;
  localparam logic [11:0] MaxYReset = 12'd200;

  // Output bus width, result padded to whole bytes
  localparam int unsigned ResW      = 43;
  localparam int unsigned OutDataW  = 48;

  // One assembled packet: header, X delta, Y delta
  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] xd;
    logic [7:0] yd;
  } pkt_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [8:0]  speed_y;
    logic [8:0]  speed_x;
    logic [11:0] cursor_y;
    logic [11:0] cursor_x;
    logic        left_button;
  } res_t;

endpackage

### sv/ps2mct_front.sv
`timescale 1ns / 1ps

module ps2mct_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic [7:0]          s_tdata_i,
  output logic                s_tready_o,
  input  ps2mct_pkg::q_status_t q_status_i,
  output logic                push_o,
  output ps2mct_pkg::pkt_t    pkt_o
);

  localparam logic [1:0] PhHdr = 2'd0;
  localparam logic [1:0] PhX   = 2'd1;
  localparam logic [1:0] PhY   = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xd_q, xd_d;
  logic       accept;

  // Stall only when the closing byte has nowhere to go
  assign s_tready_o = !((phase_q == PhY) && q_status_i.full);
  assign accept     = s_tvalid_i && s_tready_o;

  // Advance through header, X and Y slots; drop unsynced headers
  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    xd_d    = xd_q;
    push_o  = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PhX: begin
          xd_d    = s_tdata_i;
          phase_d = PhY;
        end
        PhY: begin
          push_o  = 1'b1;
          phase_d = PhHdr;
        end
        default: begin
          if (s_tdata_i[ps2mct_pkg::HdrSyncBit]) begin
            hdr_d   = s_tdata_i;
            phase_d = PhX;
          end else begin
            phase_d = PhHdr;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Hold header and X delta until the packet closes
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    xd_q  <= xd_d;
  end

  assign pkt_o.hdr = hdr_q;
  assign pkt_o.xd  = xd_q;
  assign pkt_o.yd  = s_tdata_i;

endmodule

### sv/ps2mct_queue.sv
`timescale 1ns / 1ps

module ps2mct_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ps2mct_pkg::pkt_t      pkt_i,
  input  logic                  pop_i,
  output ps2mct_pkg::pkt_t      pkt_o,
  output ps2mct_pkg::q_status_t status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ps2mct_pkg::pkt_t slot_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming packets
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= pkt_i;
    end
  end

  assign pkt_o          = slot_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.valid = (count_q != '0);

endmodule

### sv/ps2mct_back.sv
`timescale 1ns / 1ps

module ps2mct_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2mct_pkg::q_status_t q_status_i,
  input  ps2mct_pkg::pkt_t      pkt_i,
  output logic                  pop_o,
  input  logic [11:0]           max_x_i,
  input  logic [11:0]           max_y_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output ps2mct_pkg::res_t      res_o
);

  // Move one axis by a magnitude plus optional overflow extra
  function automatic logic [13:0] axis_step(input logic [11:0] pos, input logic [8:0] mag,
                                            input logic ovf, input logic up);
    logic [9:0] ext;
    ext = {1'b0, mag} + (ovf ? ps2mct_pkg::OvfExtra : 10'd0);
    return up ? ({2'b00, pos} + {4'b0000, ext}) : ({2'b00, pos} - {4'b0000, ext});
  endfunction

  // Clamp a signed 14-bit position to 0..limit
  function automatic logic [11:0] clamp_axis(input logic [13:0] v, input logic [11:0] limit);
    logic [11:0] r;
    if (v[13]) begin
      r = '0;
    end else if (v[12:0] > {1'b0, limit}) begin
      r = limit;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  logic [11:0]      pos_x_q, pos_x_d;
  logic [11:0]      pos_y_q, pos_y_d;
  logic             valid_q;
  ps2mct_pkg::res_t res_q, res_d;
  logic [8:0]       mag_x, mag_y;
  logic             sx, sy;

  // Take a packet when the output register is free or draining
  assign pop_o = q_status_i.valid && (!valid_q || m_tready_i);

  assign sx    = pkt_i.hdr[ps2mct_pkg::HdrXSignBit];
  assign sy    = pkt_i.hdr[ps2mct_pkg::HdrYSignBit];
  assign mag_x = sx ? (ps2mct_pkg::NegBase - {1'b0, pkt_i.xd}) : {1'b0, pkt_i.xd};
  assign mag_y = sy ? (ps2mct_pkg::NegBase - {1'b0, pkt_i.yd}) : {1'b0, pkt_i.yd};

  // Apply deltas; Y grows downward
  always_comb begin
    pos_x_d = clamp_axis(axis_step(pos_x_q, mag_x, pkt_i.hdr[ps2mct_pkg::HdrXOvfBit], !sx),
                         max_x_i);
    pos_y_d = clamp_axis(axis_step(pos_y_q, mag_y, pkt_i.hdr[ps2mct_pkg::HdrYOvfBit], sy),
                         max_y_i);
    res_d.left_button = pkt_i.hdr[ps2mct_pkg::HdrLeftBit];
    res_d.cursor_x    = pos_x_d;
    res_d.cursor_y    = pos_y_d;
    res_d.speed_x     = mag_x;
    res_d.speed_y     = mag_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        valid_q <= 1'b1;
      end else if (m_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid_o = valid_q;
  assign res_o      = res_q;

endmodule

### sv/ps2_mouse_cursor_tracker_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte
// m_axis    out        tdata[47:0] left_button, cursor_x, cursor_y, speed_x, speed_y
// cfg       in         cfg_idx_i 0 max_x, 1 max_y; cfg_wdata_i[11:0]
//
// One byte is taken every cycle unless the closing byte of a packet waits on a full queue;
// a packet passes from the front stage through the queue to the back stage with its output register.
// The back updates the cursor once per cycle while its output register is free or draining, one add and clamp per axis.
// Reset clears the packet phase, the cursor to 0,0 and the limits to 320 and 200.
// A stalled output fills the queue; only the closing byte of a packet then waits.

`include "assert_macros.svh"

module ps2_mouse_cursor_tracker_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,   // [7:0] data_byte
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] left_button, [12:1] cursor_x, [24:13] cursor_y, [33:25] speed_x,
  // [42:34] speed_y, [47:43] zero
  output logic [ps2mct_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [ps2mct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ps2mct_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic [11:0]           max_x_q;
  logic [11:0]           max_y_q;
  logic                  push;
  logic                  pop;
  ps2mct_pkg::pkt_t      pkt_in;
  ps2mct_pkg::pkt_t      pkt_out;
  ps2mct_pkg::q_status_t q_status;
  ps2mct_pkg::res_t      res;

  // Write limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= ps2mct_pkg::MaxXReset;
      max_y_q <= ps2mct_pkg::MaxYReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2mct_pkg::CfgMaxX: max_x_q <= cfg_wdata_i;
        ps2mct_pkg::CfgMaxY: max_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ps2mct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tready_o (s_axis_tready_o),
    .q_status_i (q_status),
    .push_o     (push),
    .pkt_o      (pkt_in)
  );

  ps2mct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pkt_i    (pkt_in),
    .pop_i    (pop),
    .pkt_o    (pkt_out),
    .status_o (q_status)
  );

  ps2mct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .pkt_i      (pkt_out),
    .pop_o      (pop),
    .max_x_i    (max_x_q),
    .max_y_i    (max_y_q),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {(ps2mct_pkg::OutDataW - ps2mct_pkg::ResW)'(0), res};

  `ASSERT_NEVER(a_push_into_full, push && q_status.full)
  `ASSERT_CLK(a_pop_needs_data, pop |-> q_status.valid)
  `ASSERT_CLK(a_result_from_pop, $rose(m_axis_tvalid_o) |-> $past(pop))

endmodule

### sim/tb_ps2_mouse_cursor_tracker_top.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_cursor_tracker_top;

  typedef enum logic [1:0] {
    AwaitHeader,
    AwaitX,
    AwaitY
  } pkt_phase_e;

  // Cursor prediction: packet assembly, kept position and pending reports
  class cursor_predictor;
    logic [11:0]          lim_x;
    logic [11:0]          lim_y;
    pkt_phase_e           phase;
    logic [7:0]           hdr;
    logic [7:0]           xd;
    logic [11:0]          pos_x;
    logic [11:0]          pos_y;
    ps2mct_pkg::res_t     expected_reports[$];
    int unsigned          errors;

    function new();
      lim_x  = ps2mct_pkg::MaxXReset;
      lim_y  = ps2mct_pkg::MaxYReset;
      phase  = AwaitHeader;
      hdr    = '0;
      xd     = '0;
      pos_x  = '0;
      pos_y  = '0;
      errors = 0;
    endfunction

    function void set_limit(logic [ps2mct_pkg::CfgIdxW-1:0] idx, logic [11:0] val);
      if (idx == ps2mct_pkg::CfgMaxX) lim_x = val;
      else if (idx == ps2mct_pkg::CfgMaxY) lim_y = val;
    endfunction

    // Advance the packet phase by one accepted mouse byte
    function void take_byte(logic [7:0] b);
      int               mag_x;
      int               mag_y;
      int               nx;
      int               ny;
      int               ext_x;
      int               ext_y;
      ps2mct_pkg::res_t rep;
      case (phase)
        AwaitX: begin
          xd    = b;
          phase = AwaitY;
        end
        AwaitY: begin
          phase = AwaitHeader;
          nx    = int'(pos_x);
          ny    = int'(pos_y);
          ext_x = hdr[ps2mct_pkg::HdrXOvfBit] ? int'(ps2mct_pkg::OvfExtra) : 0;
          ext_y = hdr[ps2mct_pkg::HdrYOvfBit] ? int'(ps2mct_pkg::OvfExtra) : 0;
          // X grows to the right
          if (!hdr[ps2mct_pkg::HdrXSignBit]) begin
            mag_x = int'(xd);
            nx    = nx + mag_x + ext_x;
          end else begin
            mag_x = int'(ps2mct_pkg::NegBase) - int'(xd);
            nx    = nx - mag_x - ext_x;
          end
          // Y grows downward, so a positive delta moves up
          if (!hdr[ps2mct_pkg::HdrYSignBit]) begin
            mag_y = int'(b);
            ny    = ny - mag_y - ext_y;
          end else begin
            mag_y = int'(ps2mct_pkg::NegBase) - int'(b);
            ny    = ny + mag_y + ext_y;
          end
          if (nx < 0) nx = 0;
          else if (nx > int'(lim_x)) nx = int'(lim_x);
          if (ny < 0) ny = 0;
          else if (ny > int'(lim_y)) ny = int'(lim_y);
          pos_x           = nx[11:0];
          pos_y           = ny[11:0];
          rep.left_button = hdr[ps2mct_pkg::HdrLeftBit];
          rep.cursor_x    = pos_x;
          rep.cursor_y    = pos_y;
          rep.speed_x     = mag_x[8:0];
          rep.speed_y     = mag_y[8:0];
          expected_reports.push_back(rep);
        end
        default: begin
          // Drop a header without the sync bit to resynchronize
          if (b[ps2mct_pkg::HdrSyncBit]) begin
            hdr   = b;
            phase = AwaitX;
          end else begin
            phase = AwaitHeader;
          end
        end
      endcase
    endfunction

    // Compare one delivered report with the oldest expectation
    function void check_report(logic [ps2mct_pkg::OutDataW-1:0] data);
      ps2mct_pkg::res_t got;
      ps2mct_pkg::res_t want;
      got = ps2mct_pkg::res_t'(data[ps2mct_pkg::ResW-1:0]);
      if (expected_reports.size() == 0) begin
        $error("unexpected report: %h", data);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.left_button != want.left_button) begin
        $error("left_button: expected %0d, actual %0d", want.left_button, got.left_button);
        errors++;
      end
      if (got.cursor_x != want.cursor_x) begin
        $error("cursor_x: expected %0d, actual %0d", want.cursor_x, got.cursor_x);
        errors++;
      end
      if (got.cursor_y != want.cursor_y) begin
        $error("cursor_y: expected %0d, actual %0d", want.cursor_y, got.cursor_y);
        errors++;
      end
      if (got.speed_x != want.speed_x) begin
        $error("speed_x: expected %0d, actual %0d", want.speed_x, got.speed_x);
        errors++;
      end
      if (got.speed_y != want.speed_y) begin
        $error("speed_y: expected %0d, actual %0d", want.speed_y, got.speed_y);
        errors++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid_i;
  logic                              s_axis_tready_o;
  logic [7:0]                        s_axis_tdata_i;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i;
  logic [ps2mct_pkg::OutDataW-1:0]   m_axis_tdata_o;
  logic                              cfg_we_i;
  logic [ps2mct_pkg::CfgIdxW-1:0]    cfg_idx_i;
  logic [ps2mct_pkg::CfgDataW-1:0]   cfg_wdata_i;

  logic tx_gaps;
  logic rx_gaps;
  logic hold_off_req;

  cursor_predictor predictor = new();

  ps2_mouse_cursor_tracker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Check every report taken from the output
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) predictor.check_report(m_axis_tdata_o);
  end

  // Output side: random back-pressure, plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready_i <= !(rx_gaps && $urandom_range(99) < 33);
    end
  end

  // Offer one byte, with random gaps ahead of it, and hold it until taken
  task automatic send_byte(logic [7:0] b);
    while (tx_gaps && $urandom_range(99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predictor.take_byte(b);
    @(negedge clk_i);
  endtask

  // Mostly whole packets with random content, some noise and stray bytes
  task automatic send_random(int n, int noise_pct);
    int taken;
    int pick;
    taken = 0;
    while (taken < n) begin
      pick = $urandom_range(99);
      if (pick >= noise_pct) begin
        send_byte(8'($urandom_range(255)) | 8'h08);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        taken += 3;
      end else if (pick < noise_pct / 2) begin
        send_byte(8'($urandom_range(255)) & 8'hF7);
      end else begin
        send_byte(8'($urandom_range(255)));
        taken++;
      end
    end
  endtask

  // Close any open packet, then wait for all reports and the pipeline tail
  task automatic settle();
    while (predictor.phase != AwaitHeader) send_byte(8'($urandom_range(255)));
    s_axis_tvalid_i <= 1'b0;
    while (predictor.expected_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limits(logic [11:0] mx, logic [11:0] my);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ps2mct_pkg::CfgMaxX;
    cfg_wdata_i <= mx;
    @(posedge clk_i);
    predictor.set_limit(ps2mct_pkg::CfgMaxX, mx);
    @(negedge clk_i);
    cfg_idx_i   <= ps2mct_pkg::CfgMaxY;
    cfg_wdata_i <= my;
    @(posedge clk_i);
    predictor.set_limit(ps2mct_pkg::CfgMaxY, my);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_directed();
    logic [7:0] seq[$] = '{
      8'h00, 8'hF7,              // headers without sync bit
      8'h09, 8'hFF, 8'h00,       // left button, X +255, Y zero
      8'h38, 8'h00, 8'h00,       // both negative, magnitude 256
      8'hC8, 8'hFF, 8'hFF,       // both positive with overflow
      8'hF9, 8'h01, 8'h01,       // all header bits but 1 and 2 set
      8'h08, 8'h80, 8'h7F        // mid-range deltas
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = ps2mct_pkg::CfgMaxX;
    cfg_wdata_i     = '0;
    tx_gaps         = 1'b1;
    rx_gaps         = 1'b1;
    hold_off_req    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset limits with hand-picked bytes
    send_directed();
    send_random(150, 20);
    settle();

    // Widest limits
    write_limits(12'd4095, 12'd4095);
    send_random(320, 10);
    settle();

    // Narrowest limits
    write_limits(12'd1, 12'd1);
    send_random(220, 20);
    settle();

    // Long output hold-off so the input stalls
    write_limits(12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)));
    hold_off_req = 1'b1;
    send_random(320, 20);
    settle();

    // No gaps on either side
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_limits(12'($urandom_range(600, 1)), 12'($urandom_range(600, 1)));
    send_random(320, 20);
    settle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // Mixed extremes
    write_limits(12'd4095, 12'd1);
    send_random(250, 20);
    settle();

    // Heavy noise, random limits up to 300
    write_limits(12'($urandom_range(300, 1)), 12'($urandom_range(300, 1)));
    send_random(320, 40);
    settle();

    if (predictor.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/ps2mct_pkg.sv
sv/ps2mct_front.sv
sv/ps2mct_queue.sv
sv/ps2mct_back.sv
sv/ps2_mouse_cursor_tracker_top.sv
sim/tb_ps2_mouse_cursor_tracker_top.sv
